// ===== design/svmm_pkg.sv =====
`timescale 1ns / 1ps

package svmm_pkg;

  // default capacities
  localparam int MAX_NOTES_DEF = 256;
  localparam int MAX_STOPS_DEF = 16;

  // field widths
  localparam int NOTE_W = 8;
  localparam int STOP_W = 4;
  localparam int VEL_W  = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int PIPE_CNT_W = 9;
  localparam int STOP_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PIPE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT = CFG_IDX_W'(1);

  localparam logic [PIPE_CNT_W-1:0] PIPE_COUNT_RST = PIPE_CNT_W'(192);
  localparam logic [STOP_CNT_W-1:0] STOP_COUNT_RST = STOP_CNT_W'(1);

  // command codes
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic              command;
    logic [NOTE_W-1:0] note_index;
    logic [STOP_W-1:0] stop_index;
    logic [VEL_W-1:0]  key_velocity;
  } item_t;

  typedef struct packed {
    logic [NOTE_W-1:0] pipe_note;
    logic [VEL_W-1:0]  pipe_velocity;
  } result_t;

endpackage

// ===== design/stop_velocity_max_merge_core.sv =====
`timescale 1ns / 1ps
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------------------
// item      | item_valid / item_ready    | item: command, note_index, stop_index, velocity
// result    | result_valid / result_ready| result: pipe_note, pipe_velocity
// cfg       | cfg_valid / cfg_ready      | cfg_index, cfg_data (0 pipe_count, 1 stop_count)
//
// a set beat goes back to idle after its check step when the maximum holds, through the
// emit step when the new velocity is the new maximum, and through a rescan of nstops =
// min(stop_count, MAX_STOPS) stop entries when the stop drops; the scan reads one stop
// entry per cycle from the single read port of the velocity ram. a clear beat sweeps
// both rams one entry per cycle, MAX_NOTES * MAX_STOPS entries (4096 at defaults). the
// same sweep runs after reset, and item_ready stays low during it; cfg writes are taken
// at any time. a result waits in its output register while the next item is accepted; a
// stalled result holds the block in its emit step only when a second one is ready to go.

module stop_velocity_max_merge_core #(
  parameter int MAX_NOTES = svmm_pkg::MAX_NOTES_DEF,
  parameter int MAX_STOPS = svmm_pkg::MAX_STOPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  svmm_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output svmm_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [svmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [svmm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import svmm_pkg::*;

  localparam int NOTE_AW   = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int VEL_DEPTH = MAX_NOTES * MAX_STOPS;
  localparam int VEL_AW    = (VEL_DEPTH > 1) ? $clog2(VEL_DEPTH) : 1;
  localparam int SCNT_W    = $clog2(MAX_STOPS + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [PIPE_CNT_W-1:0] pipe_count;
  logic [STOP_CNT_W-1:0] stop_count;

  // item context
  logic [NOTE_W-1:0]  note_r;
  logic [NOTE_AW-1:0] note_addr;
  logic [VEL_AW-1:0]  base_addr;
  logic [VEL_AW-1:0]  entry_addr;
  logic [VEL_W-1:0]   vel_r;
  logic [SCNT_W-1:0]  nstops;
  logic [VEL_W-1:0]   new_max;

  // clear sweep and scan
  logic [VEL_AW-1:0]  clr_addr;
  logic [SCNT_W-1:0]  scan_cnt;
  logic               scan_pend;
  logic [VEL_W-1:0]   scan_max;

  // ram ports
  logic               vel_we;
  logic [VEL_AW-1:0]  vel_waddr;
  logic [VEL_W-1:0]   vel_wdata;
  logic [VEL_AW-1:0]  vel_raddr;
  logic [VEL_W-1:0]   vel_rdata;
  logic               max_we;
  logic [NOTE_AW-1:0] max_waddr;
  logic [VEL_W-1:0]   max_wdata;
  logic [NOTE_AW-1:0] max_raddr;
  logic [VEL_W-1:0]   max_rdata;

  // decode of the incoming beat
  logic               in_range;
  logic [NOTE_AW-1:0] item_note_addr;
  logic [VEL_AW-1:0]  item_base;
  logic [SCNT_W-1:0]  nstops_now;
  logic               item_acc;
  logic               res_free;
  logic [VEL_W-1:0]   scan_final;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign item_acc   = item_valid && item_ready;
  assign res_free   = !result_valid || result_ready;

  // stop count clipped to capacity
  assign nstops_now = (32'(stop_count) > MAX_STOPS) ? SCNT_W'(MAX_STOPS)
                                                    : SCNT_W'(stop_count);

  // ignore notes past the rank or the table, and stops past the registered set
  assign in_range = (32'(item.note_index) < 32'(pipe_count)) &&
                    (32'(item.note_index) < MAX_NOTES) &&
                    (32'(item.stop_index) < 32'(nstops_now));

  assign item_note_addr = NOTE_AW'(item.note_index);
  assign item_base      = VEL_AW'(item_note_addr) * VEL_AW'(MAX_STOPS);

  // last scanned entry folds into the running maximum
  assign scan_final = (vel_rdata > scan_max) ? vel_rdata : scan_max;

  // ram read addresses: item lookup while idle, stop entries while scanning
  always_comb begin
    vel_raddr = item_base + VEL_AW'(item.stop_index);
    if (state == S_SCAN) begin
      vel_raddr = base_addr + VEL_AW'(scan_cnt);
    end
    max_raddr = item_note_addr;
  end

  // ram writes: zero sweep, stored velocity, new maximum
  always_comb begin
    vel_we    = 1'b0;
    vel_waddr = entry_addr;
    vel_wdata = vel_r;
    max_we    = 1'b0;
    max_waddr = note_addr;
    max_wdata = new_max;
    unique case (state)
      S_CLEAR: begin
        vel_we    = 1'b1;
        vel_waddr = clr_addr;
        vel_wdata = '0;
        max_we    = (32'(clr_addr) < MAX_NOTES);
        max_waddr = NOTE_AW'(clr_addr);
        max_wdata = '0;
      end
      S_CHECK: begin
        vel_we = 1'b1;
      end
      S_EMIT: begin
        max_we = 1'b1;
      end
      S_IDLE, S_SCAN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      pipe_count   <= PIPE_COUNT_RST;
      stop_count   <= STOP_COUNT_RST;
      result_valid <= 1'b0;
      scan_pend    <= 1'b0;
      scan_cnt     <= '0;
    end else begin
      // register writes, any other index is dropped
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PIPE_COUNT) begin
          pipe_count <= PIPE_CNT_W'(cfg_data);
        end else if (cfg_index == REG_STOP_COUNT) begin
          stop_count <= STOP_CNT_W'(cfg_data);
        end
      end

      // the emit step reloads the output register on its own
      if (result_valid && result_ready && state != S_EMIT) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + VEL_AW'(1);
          if (clr_addr == VEL_AW'(VEL_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (item_acc) begin
            if (item.command == CMD_CLEAR) begin
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else if (in_range) begin
              // reads of the old entry and the note maximum are in flight
              note_r     <= item.note_index;
              note_addr  <= item_note_addr;
              base_addr  <= item_base;
              entry_addr <= item_base + VEL_AW'(item.stop_index);
              vel_r      <= item.key_velocity;
              nstops     <= nstops_now;
              state      <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          // vel_rdata is the old stop entry, max_rdata the note maximum
          if (vel_r > max_rdata ||
              (vel_r == max_rdata && vel_r < vel_rdata)) begin
            new_max <= vel_r;
            state   <= S_EMIT;
          end else if (vel_r < vel_rdata) begin
            // the stop dropped below its old value: rescan all stops
            scan_cnt  <= '0;
            scan_pend <= 1'b0;
            scan_max  <= '0;
            state     <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end

        S_SCAN: begin
          if (scan_cnt != nstops) begin
            scan_cnt  <= scan_cnt + SCNT_W'(1);
            scan_pend <= 1'b1;
          end else begin
            scan_pend <= 1'b0;
          end
          if (scan_pend) begin
            scan_max <= scan_final;
          end
          if (scan_pend && scan_cnt == nstops) begin
            new_max <= scan_final;
            state   <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (res_free) begin
            result       <= '{pipe_note: note_r, pipe_velocity: new_max};
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  svmm_ram #(
    .WIDTH(VEL_W),
    .DEPTH(VEL_DEPTH)
  ) u_vel_ram (
    .clk  (clk),
    .we   (vel_we),
    .waddr(vel_waddr),
    .wdata(vel_wdata),
    .raddr(vel_raddr),
    .rdata(vel_rdata)
  );

  svmm_ram #(
    .WIDTH(VEL_W),
    .DEPTH(MAX_NOTES)
  ) u_max_ram (
    .clk  (clk),
    .we   (max_we),
    .waddr(max_waddr),
    .wdata(max_wdata),
    .raddr(max_raddr),
    .rdata(max_rdata)
  );

endmodule

// ===== design/svmm_ram.sv =====
`timescale 1ns / 1ps

module svmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/svmm_checker.sv =====
`timescale 1ns / 1ps

module svmm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            item_valid,
  input logic                            item_ready,
  input svmm_pkg::item_t                 item,
  input logic                            result_valid,
  input logic                            result_ready,
  input svmm_pkg::result_t               result,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [svmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [svmm_pkg::CFG_DATA_W-1:0] cfg_data
);

  import svmm_pkg::*;

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // clearing sweep blocks items right after reset
  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !item_ready)
    else $error("item taken during the reset sweep");

  // a clear beat starts the sweep and closes the item channel next cycle
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.command == CMD_CLEAR |=> !item_ready)
    else $error("item taken while the clear sweep runs");

  // register writes are never stalled
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("cfg write stalled");

endmodule

bind stop_velocity_max_merge_core svmm_checker u_svmm_checker (.*);
